// File: rtl/tkips_pkg.sv
// ============================================================================
// tkips_pkg : shared types and constants of the top-k inner product search
// Sizes, field widths, command and register codes, the sequencer state and
// the structs that pass between the top level and the dot product unit.
// ============================================================================
package tkips_pkg;

   // store sizes
   localparam int MAX_VECTORS = 4096;
   localparam int MAX_DIM     = 128;
   localparam int MAX_RESULTS = 16;

   // field widths
   localparam int VEC_W   = 12;
   localparam int DIM_W   = 7;
   localparam int RANK_W  = 4;
   localparam int VALUE_W = 16;
   localparam int PROD_W  = 32;
   localparam int SCORE_W = 39;
   localparam int OP_W    = 2;
   localparam int COUNT_W = 5;    // holds 0 .. MAX_RESULTS

   // configuration register widths
   localparam int CFG_VC_W  = 13;
   localparam int CFG_DIM_W = 8;
   localparam int CFG_RC_W  = 5;
   localparam int PADDR_W   = 4;
   localparam int PDATA_W   = 32;
   localparam int REG_IDX_W = 2;

   // request opcodes
   localparam logic [OP_W-1:0] OP_WRITE_BASE  = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE_QUERY = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH      = 2'd2;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_VECTOR_COUNT = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_DIMENSION    = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_RESULT_COUNT = 2'd2;

   // sequencer state
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   // store write request
   typedef struct packed {
      logic                      base_we;
      logic                      query_we;
      logic [VEC_W-1:0]          vslot;
      logic [DIM_W-1:0]          cslot;
      logic signed [VALUE_W-1:0] value;
   } wr_type;

   // one component read issued to the dot product unit
   typedef struct packed {
      logic             valid;
      logic [VEC_W-1:0] vec;
      logic [DIM_W-1:0] comp;
      logic             first;   // first component of a vector
      logic             last;    // last component of a vector
      logic             done;    // last component of the whole scan
   } issue_type;

   // finished score of one base vector
   typedef struct packed {
      logic                      valid;
      logic [VEC_W-1:0]          index;
      logic signed [SCORE_W-1:0] score;
      logic                      done;
   } score_type;

endpackage

// File: rtl/tkips_dot_unit.sv
// ============================================================================
// tkips_dot_unit : vector stores and multiply-accumulate pipeline
// Holds the base and query stores in synchronous RAM. Each issued component
// is read, multiplied and accumulated; one score leaves per base vector.
// ============================================================================
module tkips_dot_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  tkips_pkg::wr_type     wr,
   input  tkips_pkg::issue_type  issue,
   output tkips_pkg::score_type  score
);
   import tkips_pkg::*;

   // stores
   logic signed [VALUE_W-1:0] base_mem  [MAX_VECTORS*MAX_DIM];
   logic signed [VALUE_W-1:0] query_mem [MAX_DIM];

   // read stage
   logic signed [VALUE_W-1:0] base_q_ff, query_q_ff;
   logic                      rd_valid_ff;
   logic [VEC_W-1:0]          rd_vec_ff;
   logic                      rd_first_ff, rd_last_ff, rd_done_ff;

   // multiply stage
   logic signed [PROD_W-1:0]  prod_in, prod_ff;
   logic                      mul_valid_ff;
   logic [VEC_W-1:0]          mul_vec_ff;
   logic                      mul_first_ff, mul_last_ff, mul_done_ff;

   // accumulate stage
   logic signed [SCORE_W-1:0] sum_in, acc_ff;
   logic                      score_valid_ff;
   logic [VEC_W-1:0]          score_index_ff;
   logic signed [SCORE_W-1:0] score_value_ff;
   logic                      score_done_ff;

   // store writes
   always_ff @(posedge clock) begin
      if (wr.base_we) begin
         base_mem[{wr.vslot, wr.cslot}] <= wr.value;
      end
      if (wr.query_we) begin
         query_mem[wr.cslot] <= wr.value;
      end
   end

   // registered store reads
   always_ff @(posedge clock) begin
      base_q_ff  <= base_mem[{issue.vec, issue.comp}];
      query_q_ff <= query_mem[issue.comp];
   end

   // read stage tags
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= issue.valid;
      end
      rd_vec_ff   <= issue.vec;
      rd_first_ff <= issue.first;
      rd_last_ff  <= issue.last;
      rd_done_ff  <= issue.done;
   end

   // product of two Q1.14 values is Q3.28
   assign prod_in = PROD_W'(base_q_ff) * PROD_W'(query_q_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= rd_valid_ff;
      end
      prod_ff      <= prod_in;
      mul_vec_ff   <= rd_vec_ff;
      mul_first_ff <= rd_first_ff;
      mul_last_ff  <= rd_last_ff;
      mul_done_ff  <= rd_done_ff;
   end

   // running sum; a new vector starts from zero
   // at most MAX_DIM products of magnitude 2^30 fit the score width
   assign sum_in = (mul_first_ff ? '0 : acc_ff)
                 + {{(SCORE_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         score_valid_ff <= 1'b0;
      end else begin
         score_valid_ff <= mul_valid_ff && mul_last_ff;
      end
      if (mul_valid_ff) begin
         acc_ff <= sum_in;
      end
      score_index_ff <= mul_vec_ff;
      score_value_ff <= sum_in;
      score_done_ff  <= mul_done_ff;
   end

   assign score.valid = score_valid_ff;
   assign score.index = score_index_ff;
   assign score.score = score_value_ff;
   assign score.done  = score_done_ff;

endmodule

// File: rtl/top_k_inner_product_search.sv
// ============================================================================
// top_k_inner_product_search : exact top-k inner product search
// Loads base and query components, scans every base vector in use with one
// multiply-accumulate per cycle and reports the best matches in rank order.
//
//   channel  direction  ports           moves
//   req      in         req_*           load or search command
//   rsp      out        rsp_*           one ranked match
//   csr      in/out     psel..pready    vector_count, dimension, result_count
//
// A load request is written into the stores as it is taken. A search scans
// vector_count * dimension components (clamped values), one per cycle through
// the store read port; each score passes the read, multiply and accumulate
// registers into the best list, and the results leave through the output
// register one per cycle while rsp_ready is high.
// No new request is taken while a search scans, drains or emits; the last result
// may still wait in the output register when the next request is taken.
// Reset is synchronous; the stores hold no reset value and get no clearing.
// ============================================================================
module top_k_inner_product_search (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [tkips_pkg::OP_W-1:0]             req_opcode,
   input  logic [tkips_pkg::VEC_W-1:0]            req_vector_slot,
   input  logic [tkips_pkg::DIM_W-1:0]            req_component_slot,
   input  logic signed [tkips_pkg::VALUE_W-1:0]   req_component_value,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [tkips_pkg::RANK_W-1:0]           rsp_rank,
   output logic [tkips_pkg::VEC_W-1:0]            rsp_match_index,
   output logic signed [tkips_pkg::SCORE_W-1:0]   rsp_match_score,
   output logic                                   rsp_final_flag,
   // configuration port
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [tkips_pkg::PADDR_W-1:0]          paddr,
   input  logic [tkips_pkg::PDATA_W-1:0]          pwdata,
   output logic [tkips_pkg::PDATA_W-1:0]          prdata,
   output logic                                   pready
);
   import tkips_pkg::*;

   // configuration
   logic [CFG_VC_W-1:0]  vector_count_ff;
   logic [CFG_DIM_W-1:0] dimension_ff;
   logic [CFG_RC_W-1:0]  result_count_ff;
   logic                 csr_write;
   logic [REG_IDX_W-1:0] csr_index;

   // search limits, taken at search start
   logic [VEC_W-1:0]     n_last_in, n_last_ff;
   logic [DIM_W-1:0]     d_last_in, d_last_ff;
   logic [COUNT_W-1:0]   k_in, k_ff;
   logic [CFG_VC_W-1:0]  n_count;
   logic [COUNT_W-1:0]   k_clamp;

   // sequencer
   state_type            state_ff, state_in;
   logic                 req_accept, search_start;
   logic [VEC_W-1:0]     vec_ff;
   logic [DIM_W-1:0]     comp_ff;
   logic                 comp_last, vec_last;

   wr_type               wr;
   issue_type            issue;
   score_type            score;

   // best list
   logic signed [SCORE_W-1:0] best_score_ff [MAX_RESULTS];
   logic [VEC_W-1:0]          best_index_ff [MAX_RESULTS];
   logic signed [SCORE_W-1:0] best_score_in [MAX_RESULTS];
   logic [VEC_W-1:0]          best_index_in [MAX_RESULTS];
   logic [MAX_RESULTS-1:0]    keep;
   logic [COUNT_W-1:0]        filled_ff;

   // result output
   logic                      out_load, emit_final;
   logic [COUNT_W-1:0]        emit_ff;
   logic                      rsp_valid_ff;
   logic [RANK_W-1:0]         rsp_rank_ff;
   logic [VEC_W-1:0]          rsp_index_ff;
   logic signed [SCORE_W-1:0] rsp_score_ff;
   logic                      rsp_final_ff;

   // ---------------------------------------------------------------------
   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[PADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         vector_count_ff <= CFG_VC_W'(1);
         dimension_ff    <= CFG_DIM_W'(1);
         result_count_ff <= CFG_RC_W'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            REG_VECTOR_COUNT: vector_count_ff <= pwdata[CFG_VC_W-1:0];
            REG_DIMENSION:    dimension_ff    <= pwdata[CFG_DIM_W-1:0];
            REG_RESULT_COUNT: result_count_ff <= pwdata[CFG_RC_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_VECTOR_COUNT: prdata = PDATA_W'(vector_count_ff);
         REG_DIMENSION:    prdata = PDATA_W'(dimension_ff);
         REG_RESULT_COUNT: prdata = PDATA_W'(result_count_ff);
         default:          prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // clamp the registers; zero acts as one, large values as the maxima
   always_comb begin
      if (vector_count_ff == '0) begin
         n_count = CFG_VC_W'(1);
      end else if (vector_count_ff > CFG_VC_W'(MAX_VECTORS)) begin
         n_count = CFG_VC_W'(MAX_VECTORS);
      end else begin
         n_count = vector_count_ff;
      end
      n_last_in = VEC_W'(n_count - CFG_VC_W'(1));

      if (dimension_ff == '0) begin
         d_last_in = '0;
      end else if (dimension_ff > CFG_DIM_W'(MAX_DIM)) begin
         d_last_in = DIM_W'(MAX_DIM - 1);
      end else begin
         d_last_in = DIM_W'(dimension_ff - CFG_DIM_W'(1));
      end

      if (result_count_ff == '0) begin
         k_clamp = COUNT_W'(1);
      end else if (result_count_ff > CFG_RC_W'(MAX_RESULTS)) begin
         k_clamp = COUNT_W'(MAX_RESULTS);
      end else begin
         k_clamp = COUNT_W'(result_count_ff);
      end
      // never more results than vectors
      if (CFG_VC_W'(k_clamp) > n_count) begin
         k_in = COUNT_W'(n_count);
      end else begin
         k_in = k_clamp;
      end
   end

   // ---------------------------------------------------------------------
   // sequencer: next state
   assign req_accept   = req_valid && req_ready;
   assign search_start = req_accept && (req_opcode == OP_SEARCH);
   assign comp_last    = (comp_ff == d_last_ff);
   assign vec_last     = (vec_ff == n_last_ff);
   assign emit_final   = ((emit_ff + COUNT_W'(1)) == filled_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (search_start) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (comp_last && vec_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (score.valid && score.done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_load && emit_final) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer: outputs
   always_comb begin
      req_ready = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_SCAN:  ;
         ST_DRAIN: ;
         ST_EMIT:  out_load  = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   assign issue.valid = (state_ff == ST_SCAN);
   assign issue.vec   = vec_ff;
   assign issue.comp  = comp_ff;
   assign issue.first = (comp_ff == '0);
   assign issue.last  = comp_last;
   assign issue.done  = comp_last && vec_last;

   // load requests go straight to the stores
   always_comb begin
      wr.base_we  = 1'b0;
      wr.query_we = 1'b0;
      unique case (req_opcode)
         OP_WRITE_BASE:  wr.base_we  = req_accept;
         OP_WRITE_QUERY: wr.query_we = req_accept;
         default: ;
      endcase
      wr.vslot = req_vector_slot;
      wr.cslot = req_component_slot;
      wr.value = req_component_value;
   end

   // state, limits and scan counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         n_last_ff <= '0;
         d_last_ff <= '0;
         k_ff      <= COUNT_W'(1);
         vec_ff    <= '0;
         comp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (search_start) begin
            n_last_ff <= n_last_in;
            d_last_ff <= d_last_in;
            k_ff      <= k_in;
            vec_ff    <= '0;
            comp_ff   <= '0;
         end else if (state_ff == ST_SCAN) begin
            if (comp_last) begin
               comp_ff <= '0;
               vec_ff  <= vec_ff + VEC_W'(1);
            end else begin
               comp_ff <= comp_ff + DIM_W'(1);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   tkips_dot_unit u_dot (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .issue (issue),
      .score (score)
   );

   // ---------------------------------------------------------------------
   // sorted insert: entries at or above the new score stay, the new score
   // goes in after them, lower entries move down one place
   always_comb begin
      for (int j = 0; j < MAX_RESULTS; j++) begin
         keep[j] = (COUNT_W'(j) < filled_ff) && (best_score_ff[j] >= score.score);
      end
      // head of the list: kept, or taken by the new score
      if (keep[0]) begin
         best_score_in[0] = best_score_ff[0];
         best_index_in[0] = best_index_ff[0];
      end else begin
         best_score_in[0] = score.score;
         best_index_in[0] = score.index;
      end
      for (int j = 1; j < MAX_RESULTS; j++) begin
         if (keep[j]) begin
            best_score_in[j] = best_score_ff[j];
            best_index_in[j] = best_index_ff[j];
         end else if (keep[j-1]) begin
            best_score_in[j] = score.score;
            best_index_in[j] = score.index;
         end else begin
            best_score_in[j] = best_score_ff[j-1];
            best_index_in[j] = best_index_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (score.valid) begin
         for (int j = 0; j < MAX_RESULTS; j++) begin
            best_score_ff[j] <= best_score_in[j];
            best_index_ff[j] <= best_index_in[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= '0;
      end else if (search_start) begin
         filled_ff <= '0;
      end else if (score.valid && (filled_ff < k_ff)) begin
         filled_ff <= filled_ff + COUNT_W'(1);
      end
   end

   // ---------------------------------------------------------------------
   // result output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         emit_ff      <= '0;
      end else begin
         if (search_start) begin
            emit_ff <= '0;
         end else if (out_load) begin
            emit_ff <= emit_ff + COUNT_W'(1);
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_rank_ff  <= emit_ff[RANK_W-1:0];
         rsp_index_ff <= best_index_ff[emit_ff[RANK_W-1:0]];
         rsp_score_ff <= best_score_ff[emit_ff[RANK_W-1:0]];
         rsp_final_ff <= emit_final;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rank        = rsp_rank_ff;
   assign rsp_match_index = rsp_index_ff;
   assign rsp_match_score = rsp_score_ff;
   assign rsp_final_flag  = rsp_final_ff;

   // ---------------------------------------------------------------------
   // checks
   a_filled_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= k_ff)
      else $error("best list holds more entries than requested");

   a_score_in_scan: assert property (@(posedge clock) disable iff (reset)
      score.valid |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("score arrived outside a scan");

   a_list_sorted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && filled_ff >= COUNT_W'(2))
         |-> (best_score_ff[0] >= best_score_ff[1]))
      else $error("best list out of order");

   a_search_start: assert property (@(posedge clock) disable iff (reset)
      search_start |=> (state_ff == ST_SCAN && filled_ff == '0))
      else $error("search did not start cleanly");

endmodule
